>>> hw/rtl/assert_macros.svh
// Assertion helpers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPLIES(label, clk, rst, a, b, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);

`define ASSERT_NEXT(label, clk, rst, a, b, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);

`endif

>>> hw/rtl/dda_pkg.sv
`default_nettype none
package dda_pkg;
   localparam int WindowWidthDefault  = 1024;
   localparam int WindowHeightDefault = 1024;

   localparam logic [2:0] CSR_SCALE  = 3'd0;
   localparam logic [2:0] CSR_SHIFTX = 3'd1;
   localparam logic [2:0] CSR_SHIFTY = 3'd2;
   localparam logic [2:0] CSR_STRIDE = 3'd3;
   localparam logic [2:0] CSR_PBYTES = 3'd4;

   localparam logic OP_START = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE, ST_PLACE, ST_PLACE_WAIT, ST_SPAN, ST_DIV, ST_DIV_WAIT,
      ST_ACTIVE, ST_EMIT, ST_OUT
   } state_type;

   // divide jobs
   localparam logic [1:0] DIV_X = 2'd0;
   localparam logic [1:0] DIV_Y = 2'd1;
   localparam logic [1:0] DIV_C = 2'd2;

   typedef struct packed {
      logic       load;      // capture input item
      logic       place_go;  // process one endpoint coordinate
      logic [1:0] place_sel; // 0 sx,1 sy,2 ex,3 ey
      logic       span;      // compute deltas and denominator
      logic       div_go;
      logic [1:0] div_sel;
      logic       div_store;
      logic       emit;      // build pixel into output regs
      logic       advance;
   } cmd_type;

   typedef struct packed {
      logic div_busy;
      logic den_zero;
      logic done;       // run end condition
   } sts_type;
endpackage
`default_nettype wire

>>> hw/rtl/dda_div.sv
`default_nettype none
// Unsigned restoring divider, one quotient bit per cycle, 64/32 -> 64.
module dda_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] dividend,
   input  wire logic [31:0] divisor,
   output logic             busy,
   output logic [63:0]      quotient
);
   import dda_pkg::*;
   logic [6:0]  cnt_ff, cnt_in;
   logic [63:0] q_ff, q_in;
   logic [32:0] r_ff, r_in;
   logic [31:0] d_ff, d_in;
   logic [32:0] trial;

   always_comb begin
      trial = {r_ff[31:0], q_ff[63]};
      cnt_in = cnt_ff; q_in = q_ff; r_in = r_ff; d_in = d_ff;
      if (start) begin
         cnt_in = 7'd64; q_in = dividend; r_in = '0; d_in = divisor;
      end else if (cnt_ff != 7'd0) begin
         cnt_in = cnt_ff - 7'd1;
         if (trial >= {1'b0, d_ff}) begin
            r_in = trial - {1'b0, d_ff};
            q_in = {q_ff[62:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[62:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) cnt_ff <= '0;
      else cnt_ff <= cnt_in;
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in;
   end

   assign busy = cnt_ff != 7'd0;
   assign quotient = q_ff;
endmodule
`default_nettype wire

>>> hw/rtl/dda_datapath.sv
`default_nettype none
module dda_datapath #(
   parameter int WINDOW_WIDTH  = dda_pkg::WindowWidthDefault,
   parameter int WINDOW_HEIGHT = dda_pkg::WindowHeightDefault
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire dda_pkg::cmd_type    cmd,
   output dda_pkg::sts_type         sts,
   input  wire logic                csr_write_enable,
   input  wire logic [2:0]          csr_index,
   input  wire logic [31:0]         csr_data,
   input  wire logic signed [31:0]  req_start_x,
   input  wire logic signed [31:0]  req_start_y,
   input  wire logic [31:0]         req_start_colour,
   input  wire logic signed [31:0]  req_end_x_in,
   input  wire logic signed [31:0]  req_end_y_in,
   input  wire logic [31:0]         req_end_colour_in,
   output logic signed [15:0]       rsp_pixel_x,
   output logic signed [15:0]       rsp_pixel_y,
   output logic [31:0]              rsp_pixel_colour,
   output logic [31:0]              rsp_byte_offset,
   output logic                     rsp_visible,
   output logic                     rsp_last
);
   import dda_pkg::*;

   logic [31:0] scale_ff;
   logic signed [31:0] shx_ff, shy_ff;
   logic [15:0] stride_ff;
   logic [3:0]  pbytes_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= 32'd65536; shx_ff <= '0; shy_ff <= '0;
         stride_ff <= 16'd4096; pbytes_ff <= 4'd4;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_SCALE:  scale_ff  <= csr_data;
            CSR_SHIFTX: shx_ff    <= csr_data;
            CSR_SHIFTY: shy_ff    <= csr_data;
            CSR_STRIDE: stride_ff <= csr_data[15:0];
            CSR_PBYTES: pbytes_ff <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   // captured item
   logic signed [31:0] in_sx_ff, in_sy_ff, in_ex_ff, in_ey_ff;
   logic [31:0] c0_ff, c1_ff;
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         in_sx_ff <= req_start_x; in_sy_ff <= req_start_y;
         in_ex_ff <= req_end_x_in; in_ey_ff <= req_end_y_in;
         c0_ff <= req_start_colour; c1_ff <= req_end_colour_in;
      end
   end

   // placement: multiply stage then truncate/saturate/shift stage
   logic signed [31:0] pl_src;
   logic signed [64:0] prod_ff;
   logic [1:0] psel_ff;
   logic pvalid_ff;
   always_comb begin
      case (cmd.place_sel)
         2'd0: pl_src = in_sx_ff;
         2'd1: pl_src = in_sy_ff;
         2'd2: pl_src = in_ex_ff;
         default: pl_src = in_ey_ff;
      endcase
   end
   always_ff @(posedge clock) begin
      prod_ff <= 65'(pl_src) * $signed({33'd0, scale_ff});
      psel_ff <= cmd.place_sel;
      if (reset) pvalid_ff <= 1'b0;
      else pvalid_ff <= cmd.place_go;
   end

   logic signed [48:0] pq;
   logic signed [31:0] ps1, pshift, placed;
   logic signed [32:0] psum;
   always_comb begin
      pq = 49'(prod_ff >>> 16);
      if (prod_ff < 0 && prod_ff[15:0] != 16'd0) pq = pq + 49'sd1;
      if (pq > 49'sh7FFFFFFF) ps1 = 32'sh7FFFFFFF;
      else if (pq < -49'sh80000000) ps1 = 32'sh80000000;
      else ps1 = pq[31:0];
      pshift = psel_ff[0] ? shy_ff : shx_ff;
      psum = 33'(ps1) + 33'(pshift);
      if (psum > 33'sh7FFFFFFF) placed = 32'sh7FFFFFFF;
      else if (psum < -33'sh80000000) placed = 32'sh80000000;
      else placed = psum[31:0];
   end

   logic signed [31:0] cx_ff, cy_ff, tx_ff, ty_ff, stx_ff, sty_ff;
   logic [47:0] cc_ff, stc_ff;
   logic [31:0] tc_ff;
   logic [32:0] adx_ff, ady_ff, den_ff;
   logic dxn_ff, dyn_ff, dcn_ff;
   logic [32:0] adc_ff;

   logic signed [32:0] dx, dy, dc;
   logic [32:0] adx, ady;
   always_comb begin
      dx = 33'(tx_ff) - 33'(cx_ff);
      dy = 33'(ty_ff) - 33'(cy_ff);
      dc = $signed({1'b0, c1_ff}) - $signed({1'b0, c0_ff});
      adx = dx[32] ? 33'(-dx) : dx;
      ady = dy[32] ? 33'(-dy) : dy;
   end

   // divider
   logic [63:0] div_num, quo;
   logic div_busy;
   always_comb begin
      case (cmd.div_sel)
         DIV_X: div_num = {15'd0, adx_ff, 16'd0};
         DIV_Y: div_num = {15'd0, ady_ff, 16'd0};
         default: div_num = {adc_ff[31:0], 32'd0};
      endcase
   end
   // den fits 32 bits for all spans; |d| spans up to 2^32-1
   logic [32:0] den_w;
   assign den_w = den_ff;
   dda_div u_div (
      .clock(clock), .reset(reset), .start(cmd.div_go), .dividend(div_num),
      .divisor(den_w[31:0]), .busy(div_busy), .quotient(quo)
   );

   logic [63:0] qfix;
   logic [47:0] qc;
   always_comb begin
      // den never reaches 2^32, as |d| is at most 2^32-1
      qfix = den_w[32] ? {32'd0, div_num[63:32]} : quo;
      qc = (qfix > 64'h7FFFFFFFFFFF) ? 48'h7FFFFFFFFFFF : qfix[47:0];
   end

   logic signed [32:0] lim_x, lim_y;
   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff <= '0; cy_ff <= '0; tx_ff <= '0; ty_ff <= '0;
         stx_ff <= '0; sty_ff <= '0; cc_ff <= '0; stc_ff <= '0; tc_ff <= '0;
      end else begin
         if (pvalid_ff) begin
            case (psel_ff)
               2'd0: cx_ff <= placed;
               2'd1: cy_ff <= placed;
               2'd2: tx_ff <= placed;
               default: ty_ff <= placed;
            endcase
         end
         if (cmd.span) begin
            adx_ff <= adx; ady_ff <= ady;
            den_ff <= (adx > ady) ? adx : ady;
            dxn_ff <= dx[32]; dyn_ff <= dy[32]; dcn_ff <= dc[32];
            adc_ff <= dc[32] ? 33'(-dc) : dc;
            cc_ff <= {c0_ff, 16'd0};
            tc_ff <= c1_ff;
            stx_ff <= '0; sty_ff <= '0; stc_ff <= '0;
         end
         if (cmd.div_store) begin
            case (cmd.div_sel)
               DIV_X: stx_ff <= dxn_ff ? -qfix[31:0] : qfix[31:0];
               DIV_Y: sty_ff <= dyn_ff ? -qfix[31:0] : qfix[31:0];
               default: stc_ff <= dcn_ff ? 48'(0 - qc) : qc;
            endcase
         end
         if (cmd.advance) begin
            cx_ff <= cx_ff + stx_ff;
            cy_ff <= cy_ff + sty_ff;
            cc_ff <= cc_ff + stc_ff;
         end
      end
   end

   // run end
   logic [31:0] astx, asty;
   logic signed [32:0] diff;
   always_comb begin
      astx = stx_ff[31] ? -stx_ff : stx_ff;
      asty = sty_ff[31] ? -sty_ff : sty_ff;
      if (astx >= asty) diff = 33'(cx_ff) - 33'(tx_ff);
      else diff = 33'(cy_ff) - 33'(ty_ff);
      lim_x = diff;
      lim_y = 33'sd0;
   end
   assign sts.done = (lim_x < 33'sd65536) && (lim_x > -33'sd65536) && (lim_y == 33'sd0);
   assign sts.div_busy = div_busy;
   assign sts.den_zero = den_ff == 33'd0;

   // emit: truncate then multiply-add
   logic signed [31:0] qx, qy;
   logic signed [15:0] px, py;
   logic signed [31:0] prx, pry;
   logic [31:0] off_y, off_x;
   always_comb begin
      qx = sts.done ? tx_ff : cx_ff;
      qy = sts.done ? ty_ff : cy_ff;
      prx = (qx < 0) ? -((-qx) >>> 16) : (qx >>> 16);
      pry = (qy < 0) ? -((-qy) >>> 16) : (qy >>> 16);
      px = prx[15:0];
      py = pry[15:0];
      off_y = {{16{py[15]}}, py} * {16'd0, stride_ff};
      off_x = {{16{px[15]}}, px} * {28'd0, pbytes_ff};
   end
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_pixel_x <= px;
         rsp_pixel_y <= py;
         rsp_pixel_colour <= sts.done ? tc_ff : cc_ff[47:16];
         rsp_byte_offset <= off_y + off_x;
         rsp_visible <= px >= 0 && 32'(px) < 32'(WINDOW_WIDTH)
                     && py >= 0 && 32'(py) < 32'(WINDOW_HEIGHT);
         rsp_last <= sts.done;
      end
   end
endmodule
`default_nettype wire

>>> hw/rtl/dda_ctrl.sv
`default_nettype none
module dda_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic             req_op,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   input  wire dda_pkg::sts_type sts,
   output dda_pkg::cmd_type      cmd
);
   import dda_pkg::*;
   state_type state_ff, state_in;
   logic [1:0] sel_ff, sel_in;
   logic act_ff, act_in;

   always_comb begin
      state_in = state_ff; sel_in = sel_ff; act_in = act_ff;
      case (state_ff)
         ST_IDLE, ST_ACTIVE: if (req_valid) begin
            if (req_op == OP_START) begin
               state_in = ST_PLACE; sel_in = 2'd0;
            end else if (act_ff) state_in = ST_EMIT;
         end
         ST_PLACE: begin
            sel_in = sel_ff + 2'd1;
            if (sel_ff == 2'd3) state_in = ST_PLACE_WAIT;
         end
         ST_PLACE_WAIT: state_in = ST_SPAN;
         ST_SPAN: begin
            sel_in = DIV_X; state_in = ST_DIV;
         end
         ST_DIV: begin
            if (sts.den_zero) begin
               state_in = ST_ACTIVE; act_in = 1'b1;
            end else state_in = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: if (!sts.div_busy) begin
            if (sel_ff == DIV_C) begin
               state_in = ST_ACTIVE; act_in = 1'b1;
            end else begin
               sel_in = sel_ff + 2'd1; state_in = ST_DIV;
            end
         end
         ST_EMIT: begin
            state_in = ST_OUT;
            if (sts.done) act_in = 1'b0;
         end
         ST_OUT: if (rsp_ready) state_in = ST_ACTIVE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      cmd.place_sel = sel_ff;
      cmd.div_sel = sel_ff;
      case (state_ff)
         ST_IDLE, ST_ACTIVE: begin
            req_ready = 1'b1;
            cmd.load = req_valid && req_op == OP_START;
         end
         ST_PLACE: cmd.place_go = 1'b1;
         ST_SPAN: cmd.span = 1'b1;
         ST_DIV: cmd.div_go = !sts.den_zero;
         ST_DIV_WAIT: cmd.div_store = !sts.div_busy;
         ST_EMIT: begin
            cmd.emit = 1'b1;
            cmd.advance = !sts.done;
         end
         ST_OUT: rsp_valid = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; sel_ff <= '0; act_ff <= 1'b0;
      end else begin
         state_ff <= state_in; sel_ff <= sel_in; act_ff <= act_in;
      end
   end
endmodule
`default_nettype wire

>>> hw/rtl/dda_line_rasterizer.sv
`default_nettype none
// DDA line rasterizer.
// Input channel req_*: op 0 starts a segment (endpoints and colours),
// op 1 is a tick asking for the next pixel. Result channel rsp_* carries
// one pixel per tick while a segment is active; ticks while idle are
// taken and give nothing.
// A start item goes through placement of its four endpoint coordinates and
// span set-up, then three divide passes (x, y, colour steps) in the serial
// divider; no further item is taken until these are done. A zero-length
// segment skips the divides. A tick goes through the emit state, which
// registers the pixel, to the output state, where the result is valid;
// the next item is taken the cycle after the result is handed off.
// csr_* writes the five configuration registers, one per cycle; the user
// must write them only while idle, as the block itself does not enforce it.
// Reset clears the state machine, positions, targets, steps and colour
// accumulators, not the captured item; configuration returns to scale
// 1.0, no shift, stride 4096, 4 bytes per pixel. If rsp_ready is low the
// result holds in its register and no further input item is taken.
module dda_line_rasterizer #(
   parameter int WINDOW_WIDTH  = dda_pkg::WindowWidthDefault,
   parameter int WINDOW_HEIGHT = dda_pkg::WindowHeightDefault
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_op,
   input  wire logic signed [31:0] req_start_x,
   input  wire logic signed [31:0] req_start_y,
   input  wire logic [31:0]        req_start_colour,
   input  wire logic signed [31:0] req_end_x_in,
   input  wire logic signed [31:0] req_end_y_in,
   input  wire logic [31:0]        req_end_colour_in,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [15:0]      rsp_pixel_x,
   output logic signed [15:0]      rsp_pixel_y,
   output logic [31:0]             rsp_pixel_colour,
   output logic [31:0]             rsp_byte_offset,
   output logic                    rsp_visible,
   output logic                    rsp_last,
   input  wire logic               csr_write_enable,
   input  wire logic [2:0]         csr_index,
   input  wire logic [31:0]        csr_data
);
   import dda_pkg::*;
`include "assert_macros.svh"
   cmd_type cmd;
   sts_type sts;

   dda_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .req_op(req_op), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .sts(sts), .cmd(cmd)
   );

   dda_datapath #(.WINDOW_WIDTH(WINDOW_WIDTH), .WINDOW_HEIGHT(WINDOW_HEIGHT)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index), .csr_data(csr_data),
      .req_start_x(req_start_x), .req_start_y(req_start_y),
      .req_start_colour(req_start_colour), .req_end_x_in(req_end_x_in),
      .req_end_y_in(req_end_y_in), .req_end_colour_in(req_end_colour_in),
      .rsp_pixel_x(rsp_pixel_x), .rsp_pixel_y(rsp_pixel_y),
      .rsp_pixel_colour(rsp_pixel_colour), .rsp_byte_offset(rsp_byte_offset),
      .rsp_visible(rsp_visible), .rsp_last(rsp_last)
   );

   `ASSERT_IMPLIES(a_no_in_while_out, clock, reset, rsp_valid, !req_ready,
      "input taken while result pending")
   `ASSERT_NEXT(a_emit_then_out, clock, reset, cmd.emit, rsp_valid,
      "emit not followed by result")
   `ASSERT_IMPLIES(a_div_store_idle, clock, reset, cmd.div_store, !sts.div_busy,
      "step stored while divider busy")
endmodule
`default_nettype wire

>>> dv/dda_pixel_checker.sv
`timescale 1ns / 1ps
module dda_pixel_checker #(
   parameter int WINDOW_WIDTH  = dda_pkg::WindowWidthDefault,
   parameter int WINDOW_HEIGHT = dda_pkg::WindowHeightDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic               req_op,
   input  logic signed [31:0] req_start_x,
   input  logic signed [31:0] req_start_y,
   input  logic [31:0]        req_start_colour,
   input  logic signed [31:0] req_end_x_in,
   input  logic signed [31:0] req_end_y_in,
   input  logic [31:0]        req_end_colour_in,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic signed [15:0] rsp_pixel_x,
   input  logic signed [15:0] rsp_pixel_y,
   input  logic [31:0]        rsp_pixel_colour,
   input  logic [31:0]        rsp_byte_offset,
   input  logic               rsp_visible,
   input  logic               rsp_last,
   input  logic               csr_write_enable,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data,
   output int                 fail_count,
   output int                 pending,
   output logic               seg_active
);
   import dda_pkg::*;

   typedef struct packed {
      logic signed [15:0] px;
      logic signed [15:0] py;
      logic [31:0]        colour;
      logic [31:0]        offset;
      logic               visible;
      logic               last;
   } pixel_type;

   pixel_type pixel_queue[$];

   logic [31:0] scale;
   longint      shx, shy;
   logic [15:0] stride;
   logic [3:0]  pbytes;

   longint      pos_x, pos_y, stp_x, stp_y, tgt_x, tgt_y;
   logic [47:0] col_acc, col_step;
   logic [31:0] tgt_col;

   function automatic longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint wrap32(longint v);
      logic [31:0] w;
      w = v[31:0];
      return longint'($signed(w));
   endfunction

   function automatic longint iabs64(longint v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic longint place_coord(logic [31:0] c, longint sh);
      longint p;
      p = longint'($signed(c)) * longint'({32'b0, scale});
      return sat32(sat32(p / 65536) + sh);
   endfunction

   function automatic pixel_type make_pixel(longint qx, longint qy, logic [31:0] col,
                                            logic lst);
      pixel_type r;
      longint    ix, iy, off;
      ix = qx / 65536;
      iy = qy / 65536;
      off = iy * longint'({48'b0, stride}) + ix * longint'({60'b0, pbytes});
      r.px = ix[15:0];
      r.py = iy[15:0];
      r.colour = col;
      r.offset = off[31:0];
      r.visible = (ix >= 0 && ix < WINDOW_WIDTH && iy >= 0 && iy < WINDOW_HEIGHT);
      r.last = lst;
      return r;
   endfunction

   task automatic load_segment();
      longint      dx, dy, den, dc;
      logic [63:0] q;
      pos_x = place_coord(req_start_x, shx);
      pos_y = place_coord(req_start_y, shy);
      tgt_x = place_coord(req_end_x_in, shx);
      tgt_y = place_coord(req_end_y_in, shy);
      dx = tgt_x - pos_x;
      dy = tgt_y - pos_y;
      den = (iabs64(dx) > iabs64(dy)) ? iabs64(dx) : iabs64(dy);
      col_acc = {req_start_colour, 16'b0};
      tgt_col = req_end_colour_in;
      if (den == 0) begin
         stp_x = 0;
         stp_y = 0;
         col_step = '0;
      end else begin
         stp_x = longint'((64'(iabs64(dx)) << 16) / 64'(den));
         if (dx < 0) stp_x = -stp_x;
         stp_y = longint'((64'(iabs64(dy)) << 16) / 64'(den));
         if (dy < 0) stp_y = -stp_y;
         dc = longint'({32'b0, req_end_colour_in}) - longint'({32'b0, req_start_colour});
         q = ($unsigned(iabs64(dc)) << 32) / $unsigned(den);
         if (q > 64'h7FFF_FFFF_FFFF) q = 64'h7FFF_FFFF_FFFF;
         col_step = (dc < 0) ? (48'd0 - q[47:0]) : q[47:0];
      end
      seg_active <= 1'b1;
   endtask

   task automatic tick_segment();
      longint diff;
      if (iabs64(stp_x) >= iabs64(stp_y)) diff = pos_x - tgt_x;
      else diff = pos_y - tgt_y;
      if (diff / 65536 == 0) begin
         pixel_queue.push_back(make_pixel(tgt_x, tgt_y, tgt_col, 1'b1));
         seg_active <= 1'b0;
      end else begin
         pixel_queue.push_back(make_pixel(pos_x, pos_y, col_acc[47:16], 1'b0));
         pos_x = wrap32(pos_x + stp_x);
         pos_y = wrap32(pos_y + stp_y);
         col_acc = col_acc + col_step;
      end
   endtask

   always @(posedge clock) begin
      pixel_type got, want;
      if (reset) begin
         scale = 32'd65536;
         shx = 0;
         shy = 0;
         stride = 16'd4096;
         pbytes = 4'd4;
         pos_x = 0; pos_y = 0; stp_x = 0; stp_y = 0; tgt_x = 0; tgt_y = 0;
         col_acc = '0; col_step = '0; tgt_col = '0;
         seg_active <= 1'b0;
         fail_count <= 0;
         pixel_queue.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_SCALE:  scale = csr_data;
               CSR_SHIFTX: shx = longint'($signed(csr_data));
               CSR_SHIFTY: shy = longint'($signed(csr_data));
               CSR_STRIDE: stride = csr_data[15:0];
               CSR_PBYTES: pbytes = csr_data[3:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_pixel_x, rsp_pixel_y, rsp_pixel_colour, rsp_byte_offset,
                    rsp_visible, rsp_last};
            if (pixel_queue.size() == 0) begin
               fail_count <= fail_count + 1;
               if (fail_count < 10) $display("unexpected pixel: %p", got);
            end else begin
               want = pixel_queue.pop_front();
               if (got !== want) begin
                  fail_count <= fail_count + 1;
                  if (fail_count < 10)
                     $display("pixel mismatch: expected %p actual %p", want, got);
               end
            end
         end
         if (req_valid && req_ready) begin
            if (req_op == OP_START) load_segment();
            else if (seg_active) tick_segment();
         end
      end
      pending <= pixel_queue.size();
   end
endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
module testbench;
   import dda_pkg::*;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_op = OP_TICK;
   logic signed [31:0] req_start_x = '0;
   logic signed [31:0] req_start_y = '0;
   logic [31:0]        req_start_colour = '0;
   logic signed [31:0] req_end_x_in = '0;
   logic signed [31:0] req_end_y_in = '0;
   logic [31:0]        req_end_colour_in = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b1;
   logic signed [15:0] rsp_pixel_x;
   logic signed [15:0] rsp_pixel_y;
   logic [31:0]        rsp_pixel_colour;
   logic [31:0]        rsp_byte_offset;
   logic               rsp_visible;
   logic               rsp_last;
   logic               csr_write_enable = 1'b0;
   logic [2:0]         csr_index = CSR_SCALE;
   logic [31:0]        csr_data = '0;

   int   fail_count, pending;
   logic seg_active;
   int   send_idle = 0;
   int   recv_idle = 0;
   bit   hold_req = 0;
   int   hold_cnt = 0;
   int   stall_cycles = 0;
   int   item_count = 0;

   always #6 clock = ~clock;

   dda_line_rasterizer u_dut (.*);

   dda_pixel_checker u_checker (.*);

   always @(negedge clock) begin
      if (hold_cnt > 0) begin
         rsp_ready = 1'b0;
         hold_cnt--;
      end else if (hold_req) begin
         hold_req = 0;
         hold_cnt = 400;
         rsp_ready = 1'b0;
      end else begin
         rsp_ready = ($urandom_range(99) >= recv_idle);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles > 3000) begin
            $display("FAIL dda_line_rasterizer");
            $finish;
         end
      end
   end

   task automatic send_item(logic op, logic [31:0] sx, logic [31:0] sy, logic [31:0] sc,
                            logic [31:0] ex, logic [31:0] ey, logic [31:0] ec);
      while ($urandom_range(99) < send_idle) @(negedge clock);
      req_op = op;
      req_start_x = sx;
      req_start_y = sy;
      req_start_colour = sc;
      req_end_x_in = ex;
      req_end_y_in = ey;
      req_end_colour_in = ec;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      req_valid = 1'b0;
      item_count++;
   endtask

   task automatic tick();
      send_item(OP_TICK, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
   endtask

   // ticks until the segment closes, or until cap ticks have been sent
   task automatic draw(int cap);
      for (int i = 0; i < cap; i++) begin
         tick();
         if (!seg_active) break;
      end
   endtask

   task automatic segment(logic [31:0] sx, logic [31:0] sy, logic [31:0] sc,
                          logic [31:0] ex, logic [31:0] ey, logic [31:0] ec, int cap);
      send_item(OP_START, sx, sy, sc, ex, ey, ec);
      draw(cap);
   endtask

   function automatic logic [31:0] coord(int span);
      int v;
      v = $urandom_range(0, 2 * span) - span;
      return (v <<< 16) | $urandom_range(0, 65535);
   endfunction

   task automatic csr_write(logic [2:0] idx, logic [31:0] val);
      csr_index = idx;
      csr_data = val;
      csr_write_enable = 1'b1;
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   task automatic settle();
      wait (pending == 0);
      repeat (300) @(negedge clock);
   endtask

   task automatic set_config(logic [31:0] sc, logic [31:0] shx, logic [31:0] shy,
                             logic [15:0] stride, logic [3:0] pb);
      settle();
      csr_write(CSR_SCALE, sc);
      csr_write(CSR_SHIFTX, shx);
      csr_write(CSR_SHIFTY, shy);
      csr_write(CSR_STRIDE, {16'b0, stride});
      csr_write(CSR_PBYTES, {28'b0, pb});
   endtask

   task automatic random_run(int count);
      int stop_at;
      stop_at = item_count + count;
      while (item_count < stop_at) begin
         case ($urandom_range(9))
            0: segment($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                       $urandom_range(1, 4));
            1: tick();
            2: segment(coord(20), coord(20), $urandom, coord(20), coord(20), $urandom,
                       $urandom_range(1, 10));
            default: segment(coord(30), coord(30), $urandom, coord(30), coord(30),
                             $urandom, 300);
         endcase
      end
   endtask

   initial begin
      repeat (9) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      tick();
      segment(32'h0003_0000, 32'h0004_0000, 32'd7, 32'h0003_8000, 32'h0004_4000,
              32'd9, 4);
      tick();
      segment(32'h0000_0000, 32'h0000_0000, 32'd0, 32'h0005_0000, 32'h0000_0000,
              32'hFFFF_FFFF, 20);
      segment(32'h0002_0000, 32'h0006_0000, 32'hFFFF_FFFF, 32'h0002_0000,
              32'hFFFD_0000, 32'h0, 20);
      segment(32'hFFFE_8000, 32'hFFFF_0000, 32'd1000, 32'h0003_0000, 32'h0402_0000,
              32'd10, 30);
      segment(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000,
              32'hFFFF_FFFF, 3);
      segment(32'h03FF_0000, 32'h0400_0000, 32'd5, 32'h0400_0000, 32'h03FE_0000,
              32'd5, 20);

      set_config(32'd0, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF, 4'hF);
      segment($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 3);
      set_config(32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'd0, 4'd0);
      segment(32'h0001_0000, 32'hFFFF_0000, 32'd3, 32'h0, 32'h0, 32'd4, 3);
      segment(32'h8000_0000, 32'h7FFF_FFFF, 32'd3, 32'h7FFF_FFFF, 32'h8000_0000,
              32'd4, 3);

      set_config(32'h0000_8000, 32'h0010_0000, 32'h0020_0000, 16'd2048, 4'd1);
      send_idle = 28;
      recv_idle = 74;
      random_run(100);

      set_config(32'h0002_0000, 32'hFFF0_0000, 32'h0, 16'd640, 4'd8);
      send_idle = 74;
      recv_idle = 28;
      random_run(100);

      set_config(32'h0001_0000, 32'h0200_0000, 32'h0200_0000, 16'd4096, 4'd4);
      send_idle = 0;
      recv_idle = 0;
      hold_req = 1;
      segment(32'h0, 32'h0, 32'd0, 32'h0028_0000, 32'h0011_0000, 32'd400, 300);
      random_run(70);

      wait (pending == 0);
      repeat (300) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS dda_line_rasterizer");
      end else begin
         $display("FAIL dda_line_rasterizer");
      end
      $finish;
   end
endmodule
